// ===== rtl/triangle_height_query_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Triangle height query unit - assertion macros
// Clocked assertion wrappers used by the evaluation engine (thq_back).
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_HEIGHT_QUERY_UNIT_DEFINES_SVH
`define TRIANGLE_HEIGHT_QUERY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define THQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("thq assertion failed");
`define THQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("thq assertion failed");
`else
`define THQ_ASSERT(lbl, clk, rstn, prop)
`define THQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/thq_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle height query - package
// Shared constants for the triangle height query unit.
// ----------------------------------------------------------------------------
`default_nettype none
package thq_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_X = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_Z = 8'd1;
endpackage
`default_nettype wire

// ===== rtl/thq_front.sv =====
// ----------------------------------------------------------------------------
// Triangle height query - front end
// Holds the query point and forms the projected edge differences per beat.
// ----------------------------------------------------------------------------
`default_nettype none
module thq_front #(
    parameter int COORD_WIDTH = thq_pkg::COORD_WIDTH,
    localparam int D1    = COORD_WIDTH + 1,
    localparam int ENT_W = 7 * D1 + 3 * COORD_WIDTH + 1,
    localparam int IN_W  = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    input  wire logic [thq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]          cfg_data,
    input  wire logic [IN_W-1:0]                 s_tdata,
    input  wire logic                            s_tlast,
    output logic      [ENT_W-1:0]                entry
);
    localparam int W = COORD_WIDTH;

    logic [W-1:0] qx_reg, qx_next, qz_reg, qz_next;

    always_comb begin
        qx_next = qx_reg;
        qz_next = qz_reg;
        if (cfg_valid) begin
            if (cfg_index == thq_pkg::CFG_QUERY_X) qx_next = cfg_data;
            if (cfg_index == thq_pkg::CFG_QUERY_Z) qz_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg <= '0;
            qz_reg <= '0;
        end else begin
            qx_reg <= qx_next;
            qz_reg <= qz_next;
        end
    end

    logic signed [D1-1:0] ax, az, bx, bz, cx, cz, px, pz;
    logic signed [D1-1:0] bzc, cxb, axc, azc, cza, pxc, pzc;

    always_comb begin
        ax  = D1'($signed(s_tdata[0*W +: W]));
        az  = D1'($signed(s_tdata[2*W +: W]));
        bx  = D1'($signed(s_tdata[3*W +: W]));
        bz  = D1'($signed(s_tdata[5*W +: W]));
        cx  = D1'($signed(s_tdata[6*W +: W]));
        cz  = D1'($signed(s_tdata[8*W +: W]));
        px  = D1'($signed(qx_reg));
        pz  = D1'($signed(qz_reg));
        bzc = bz - cz;
        cxb = cx - bx;
        axc = ax - cx;
        azc = az - cz;
        cza = cz - az;
        pxc = px - cx;
        pzc = pz - cz;
        entry = {s_tlast, s_tdata[7*W +: W], s_tdata[4*W +: W], s_tdata[1*W +: W],
                 pzc, pxc, cza, azc, axc, cxb, bzc};
    end
endmodule
`default_nettype wire

// ===== rtl/thq_queue.sv =====
// ----------------------------------------------------------------------------
// Triangle height query - queue
// Short shifting queue between the front end and the evaluation engine.
// ----------------------------------------------------------------------------
`default_nettype none
module thq_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = thq_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] rd_data
);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [CW-1:0]    count_reg, count_next, wr_pos;
    logic             do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[0];
    assign do_pop    = pop && not_empty;
    assign wr_pos    = count_reg - CW'(do_pop);

    always_comb begin
        count_next = count_reg + CW'(push && !full) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (push && !full && wr_pos == CW'(i)) begin
                slot_reg[i] <= wr_data;
            end else if (do_pop && i < DEPTH - 1) begin
                slot_reg[i] <= slot_reg[(i + 1) % DEPTH];
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/thq_back.sv =====
// ----------------------------------------------------------------------------
// Triangle height query - evaluation engine
// Edge functions and interpolation on a shared multiplier, restoring divider,
// running maximum and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_height_query_unit_defines.svh"
module thq_back #(
    parameter int COORD_WIDTH = thq_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = thq_pkg::FRAC_BITS,
    localparam int D1    = COORD_WIDTH + 1,
    localparam int ENT_W = 7 * D1 + 3 * COORD_WIDTH + 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    input  wire logic [ENT_W-1:0]       q_data,
    output logic                        q_pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_found,
    output logic      [COORD_WIDTH-1:0] m_height
);
    localparam int W   = COORD_WIDTH;
    localparam int CH  = (W + 3) / 2;
    localparam int SH  = CH - 1;
    localparam int EW  = 2 * W + 5;
    localparam int PW  = EW + CH;
    localparam int ACW = 3 * W + 8;
    localparam int DW  = ACW + 2;
    localparam int QB  = W + 1;
    localparam int QCW = $clog2(QB);
    localparam logic [63:0] EPS64 =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd50000) / 64'd100000;
    localparam logic [EW-1:0] EPS = EW'(EPS64);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_ADD   = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_EVAL  = 4'd4;
    localparam logic [3:0] ST_DPREP = 4'd5;
    localparam logic [3:0] ST_DNORM = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    localparam logic [4:0] STEP_DEN = 5'd3;
    localparam logic [4:0] STEP_E1  = 5'd7;
    localparam logic [4:0] STEP_E2  = 5'd11;
    localparam logic [4:0] STEP_NUM = 5'd17;
    localparam logic [4:0] STEP_INT = 5'd12;

    logic [3:0]           state_reg, state_next;
    logic [4:0]           step_reg, step_next;
    logic [ENT_W-1:0]     cur_reg, cur_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [ACW-1:0] acc_reg, acc_next;
    logic signed [EW-1:0] den_reg, den_next, e1_reg, e1_next;
    logic signed [EW-1:0] e2_reg, e2_next, e3_reg, e3_next;
    logic [DW-1:0]        rem_reg, rem_next, dsh_reg, dsh_next;
    logic [QB-1:0]        quo_reg, quo_next;
    logic [QCW-1:0]       cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [W-1:0]         best_reg, best_next;
    logic                 hit_reg, hit_next;
    logic                 ovalid_reg, ovalid_next, ofound_reg, ofound_next;
    logic [W-1:0]         oheight_reg, oheight_next;

    logic signed [D1-1:0] bzc, cxb, axc, azc, cza, pxc, pzc;
    logic [W-1:0]         ay, by, cy;
    logic                 last;
    logic signed [EW-1:0] a_op;
    logic signed [D1-1:0] b_src;
    logic signed [CH-1:0] b_op;
    logic signed [ACW-1:0] acc_sum;
    logic signed [EW-1:0] e3_raw;
    logic [DW-1:0]        n_val;
    logic [QB-1:0]        q_signed;
    logic [W-1:0]         y_val;
    logic                 pass;

    always_comb begin
        bzc  = cur_reg[0*D1 +: D1];
        cxb  = cur_reg[1*D1 +: D1];
        axc  = cur_reg[2*D1 +: D1];
        azc  = cur_reg[3*D1 +: D1];
        cza  = cur_reg[4*D1 +: D1];
        pxc  = cur_reg[5*D1 +: D1];
        pzc  = cur_reg[6*D1 +: D1];
        ay   = cur_reg[7*D1 +: W];
        by   = cur_reg[7*D1+W +: W];
        cy   = cur_reg[7*D1+2*W +: W];
        last = cur_reg[7*D1+3*W];

        unique case (step_reg[4:1])
            4'd0:    begin a_op = EW'(bzc); b_src = axc; end
            4'd1:    begin a_op = EW'(cxb); b_src = azc; end
            4'd2:    begin a_op = EW'(bzc); b_src = pxc; end
            4'd3:    begin a_op = EW'(cxb); b_src = pzc; end
            4'd4:    begin a_op = EW'(cza); b_src = pxc; end
            4'd5:    begin a_op = EW'(axc); b_src = pzc; end
            4'd6:    begin a_op = e1_reg;   b_src = D1'($signed(ay)); end
            4'd7:    begin a_op = e2_reg;   b_src = D1'($signed(by)); end
            4'd8:    begin a_op = e3_reg;   b_src = D1'($signed(cy)); end
            default: begin a_op = '0;       b_src = '0; end
        endcase
        if (step_reg[0]) b_op = CH'($signed(b_src[W:CH-1]));
        else             b_op = $signed({1'b0, b_src[CH-2:0]});

        if (step_reg[0]) acc_sum = acc_reg + (ACW'(prod_reg) <<< SH);
        else             acc_sum = acc_reg + ACW'(prod_reg);

        e3_raw   = den_reg - e1_reg - e2_reg;
        pass     = (den_reg >= EPS) && !e1_reg[EW-1] && !e2_reg[EW-1] && !e3_reg[EW-1];
        n_val    = (DW'(acc_reg) << 1) + DW'(den_reg);
        q_signed = neg_reg ? (~quo_reg + QB'(1)) : quo_reg;
        y_val    = q_signed[W-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cur_next     = cur_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        den_next     = den_reg;
        e1_next      = e1_reg;
        e2_next      = e2_reg;
        e3_next      = e3_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        best_next    = best_reg;
        hit_next     = hit_reg;
        ovalid_next  = ovalid_reg && !m_ready;
        ofound_next  = ofound_reg;
        oheight_next = oheight_reg;
        q_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cur_next   = q_data;
                    step_next  = '0;
                    acc_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = a_op * b_op;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                acc_next   = acc_sum;
                step_next  = step_reg + 5'd1;
                state_next = ST_MUL;
                priority case (step_reg)
                    STEP_DEN: begin den_next = EW'(acc_sum); acc_next = '0; end
                    STEP_E1:  begin e1_next  = EW'(acc_sum); acc_next = '0; end
                    STEP_E2:  begin
                        e2_next    = EW'(acc_sum);
                        state_next = ST_CHECK;
                    end
                    STEP_NUM: state_next = ST_DPREP;
                    default:  ;
                endcase
            end
            ST_CHECK: begin
                if (den_reg[EW-1]) begin
                    den_next = -den_reg;
                    e1_next  = -e1_reg;
                    e2_next  = -e2_reg;
                    e3_next  = -e3_raw;
                end else begin
                    e3_next  = e3_raw;
                end
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                acc_next  = '0;
                step_next = STEP_INT;
                state_next = pass ? ST_MUL : ST_FIN;
            end
            ST_DPREP: begin
                rem_next   = n_val;
                dsh_next   = DW'(den_reg) << QB;
                quo_next   = '0;
                cnt_next   = QCW'(QB - 1);
                state_next = ST_DNORM;
            end
            ST_DNORM: begin
                neg_next = rem_reg[DW-1];
                if (rem_reg[DW-1]) rem_next = ~rem_reg + (DW'(den_reg) << 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[QB-2:0], 1'b1};
                end else begin
                    quo_next = {quo_reg[QB-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - QCW'(1);
                if (cnt_reg == '0) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!hit_reg || $signed(y_val) > $signed(best_reg)) begin
                    best_next = y_val;
                    hit_next  = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!last) begin
                    state_next = ST_IDLE;
                end else if (!ovalid_reg || m_ready) begin
                    ovalid_next  = 1'b1;
                    ofound_next  = hit_reg;
                    oheight_next = hit_reg ? best_reg : '0;
                    best_next    = {1'b1, {(W-1){1'b0}}};
                    hit_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            best_reg   <= {1'b1, {(W-1){1'b0}}};
            hit_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            best_reg   <= best_next;
            hit_reg    <= hit_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        den_reg     <= den_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        e3_reg      <= e3_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        ofound_reg  <= ofound_next;
        oheight_reg <= oheight_next;
    end

    assign m_valid  = ovalid_reg;
    assign m_found  = ofound_reg;
    assign m_height = oheight_reg;

    `THQ_ASSERT(a_pop_idle, aclk, aresetn, q_pop |-> state_reg == ST_IDLE)
    `THQ_ASSERT(a_pop_start, aclk, aresetn, q_pop |=> state_reg == ST_MUL)
    `THQ_ASSERT(a_result_last, aclk, aresetn, $rose(ovalid_reg) |-> $past(last))
    `THQ_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> state_reg == ST_IDLE)
endmodule
`default_nettype wire

// ===== rtl/triangle_height_query_unit.sv =====
// Each triangle takes 12 passes of one shared multiply-accumulate if it misses
// and 18 if it hits, where a hit also runs a 33-step restoring divider; the
// result beat is registered once the last triangle of the mesh is done.
// One triangle is evaluated at a time; a two-beat queue decouples the input.
// Reset (aresetn low, synchronous) clears the query point, queue and maximum.
// ----------------------------------------------------------------------------
// Triangle height query unit - top level
// Highest interpolated height of a streamed mesh under a query point.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_height_query_unit #(
    parameter int COORD_WIDTH = thq_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = thq_pkg::FRAC_BITS,
    localparam int IN_W  = ((9 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [thq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]          cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  wire logic [IN_W-1:0]                 s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // height
    output logic      [OUT_W-1:0]                m_tdata,
    // found
    output logic      [0:0]                      m_tuser
);
    localparam int D1    = COORD_WIDTH + 1;
    localparam int ENT_W = 7 * D1 + 3 * COORD_WIDTH + 1;

    logic [ENT_W-1:0]       entry, q_data;
    logic                   q_full, q_valid, q_pop, found;
    logic [COORD_WIDTH-1:0] height;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign m_tdata   = OUT_W'(height);
    assign m_tuser   = found;

    thq_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .entry(entry)
    );

    thq_queue #(.WIDTH(ENT_W), .DEPTH(thq_pkg::QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(s_tvalid), .wr_data(entry), .full(q_full),
        .pop(q_pop), .not_empty(q_valid), .rd_data(q_data)
    );

    thq_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_found(found), .m_height(height)
    );
endmodule
`default_nettype wire
